[sv/apr_pkg.sv]
// ----------------------------------------------------------------------------
// apr_pkg
// Shared types and constants for the aging page replacement block.
// ----------------------------------------------------------------------------
package apr_pkg;

  localparam int MAX_FRAMES    = 16;
  localparam int PAGE_BITS     = 16;
  localparam int FRAME_INDEX_W = 4;
  localparam int IDX_W         = ($clog2(MAX_FRAMES) > FRAME_INDEX_W) ?
                                 $clog2(MAX_FRAMES) : FRAME_INDEX_W;
  localparam int NCNT_W        = IDX_W + 1;
  localparam int FRAMES_W      = 5;
  localparam int AGE_W         = 8;
  localparam int FAULT_W       = 32;
  localparam int APB_AW        = 3;
  localparam int APB_DW        = 32;

  localparam logic [AGE_W-1:0]    AGE_TOP      = 8'h80;
  localparam logic [FRAMES_W-1:0] FRAMES_RESET = 5'd4;
  localparam logic [FAULT_W-1:0]  FAULT_MAX    = '1;

  // register index, taken from paddr[2]
  localparam logic REG_FRAMES_IN_USE = 1'b0;

  typedef struct packed {
    logic [PAGE_BITS-1:0] page_ref;
    logic                 restart;
  } in_t;

  typedef struct packed {
    logic                     hit;
    logic [FRAME_INDEX_W-1:0] frame_index;
    logic                     evicted_valid;
    logic [PAGE_BITS-1:0]     evicted_page;
    logic [FAULT_W-1:0]       fault_count;
  } out_t;

  // search token rippling down the cell chain
  typedef struct packed {
    logic                 found;
    logic [IDX_W-1:0]     fidx;
    logic                 hemp;
    logic [IDX_W-1:0]     eidx;
    logic                 bv;
    logic [AGE_W-1:0]     best;
    logic [IDX_W-1:0]     bidx;
    logic [PAGE_BITS-1:0] bpage;
  } tok_t;

  // broadcast command from the controller to every cell
  typedef struct packed {
    logic                 clear;
    logic                 commit;
    logic                 hit;
    logic [IDX_W-1:0]     slot;
    logic [PAGE_BITS-1:0] page;
    logic [NCNT_W-1:0]    n_act;
  } cmd_t;

endpackage

[sv/apr_if.sv]
// ----------------------------------------------------------------------------
// apr_in_if / apr_out_if
// Valid/ready channels carrying page references and replacement results.
// ----------------------------------------------------------------------------
interface apr_in_if;
  logic         valid;
  logic         ready;
  apr_pkg::in_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface apr_out_if;
  logic          valid;
  logic          ready;
  apr_pkg::out_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

[sv/apr_cell.sv]
// ----------------------------------------------------------------------------
// apr_cell
// One frame: page, valid bit and age. Folds its frame into the search token
// and registers it toward the next cell; applies aging and fills on commit.
// ----------------------------------------------------------------------------
module apr_cell (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic [apr_pkg::IDX_W-1:0]  idx_i,
  input  apr_pkg::cmd_t              cmd_i,
  input  apr_pkg::tok_t              tok_i,
  output apr_pkg::tok_t              tok_o
);

  logic                            valid_q, valid_d;
  logic [apr_pkg::AGE_W-1:0]       age_q, age_d;
  logic [apr_pkg::PAGE_BITS-1:0]   page_q;
  apr_pkg::tok_t                   tok_q, tok_d;
  logic [apr_pkg::AGE_W-1:0]       aged;
  logic                            active;
  logic                            sel;

  assign active = {1'b0, idx_i} < cmd_i.n_act;
  assign sel    = (idx_i == cmd_i.slot);
  assign aged   = age_q >> 1;

  // search works on the aged value; ages only move at commit or clear
  always_comb begin
    tok_d = tok_i;
    if (active) begin
      if (!tok_i.found && valid_q && (page_q == cmd_i.page)) begin
        tok_d.found = 1'b1;
        tok_d.fidx  = idx_i;
      end
      if (!tok_i.hemp) begin
        if (!valid_q) begin
          tok_d.hemp = 1'b1;
          tok_d.eidx = idx_i;
        end else if (!tok_i.bv || (aged < tok_i.best)) begin
          tok_d.bv    = 1'b1;
          tok_d.best  = aged;
          tok_d.bidx  = idx_i;
          tok_d.bpage = page_q;
        end
      end
    end
  end

  always_comb begin
    valid_d = valid_q;
    age_d   = age_q;
    if (cmd_i.clear) begin
      valid_d = 1'b0;
      age_d   = '0;
    end else if (cmd_i.commit && active) begin
      age_d = aged;
      if (sel) begin
        if (cmd_i.hit) begin
          age_d = aged | apr_pkg::AGE_TOP;
        end else begin
          age_d   = apr_pkg::AGE_TOP;
          valid_d = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      age_q   <= '0;
      tok_q   <= '0;
    end else begin
      valid_q <= valid_d;
      age_q   <= age_d;
      tok_q   <= tok_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.commit && active && sel && !cmd_i.hit) begin
      page_q <= cmd_i.page;
    end
  end

  assign tok_o = tok_q;

endmodule

[sv/aging_page_replacement.sv]
// ----------------------------------------------------------------------------
// aging_page_replacement
// Aging page replacement over a chain of frame cells with 8-bit ages.
// ----------------------------------------------------------------------------
// One page reference is taken at a time and yields one result. After the
// transfer the search token passes through the cell chain one cell per cycle
// (a restart clears all frames at the input transfer). The commit step then
// ages the active frames, updates the chosen frame and loads the result
// register; it waits while a previous result is still untaken on the output.
// The result stays on the output until it is taken. The next reference is
// taken the cycle after commit, even while the previous result still waits
// on the output. frames_in_use is written through the APB port at byte
// address 0; zero acts as one frame and values above MAX_FRAMES act as
// MAX_FRAMES.
// ----------------------------------------------------------------------------
module aging_page_replacement (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  apr_in_if.sink                        in_i,
  apr_out_if.source                     out_o,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [apr_pkg::APB_AW-1:0]    paddr,
  input  logic [apr_pkg::APB_DW-1:0]    pwdata,
  output logic [apr_pkg::APB_DW-1:0]    prdata,
  output logic                          pready
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_COMMIT
  } state_e;

  state_e                             state_q;
  logic [apr_pkg::IDX_W-1:0]          cnt_q;
  logic [apr_pkg::PAGE_BITS-1:0]      page_q;
  logic [apr_pkg::FAULT_W-1:0]        fault_q, fault_d;
  logic                               out_valid_q;
  apr_pkg::out_t                      out_q;
  logic [apr_pkg::FRAMES_W-1:0]       frames_q;

  logic                               in_fire;
  logic                               commit;
  logic                               cfg_wr;
  logic [apr_pkg::NCNT_W-1:0]         n_act;
  logic [apr_pkg::IDX_W-1:0]          slot;
  apr_pkg::tok_t                      fin;
  apr_pkg::cmd_t                      cmd;
  apr_pkg::tok_t                      tok_w [apr_pkg::MAX_FRAMES+1];

  // ---------------- configuration ----------------
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr[2] == apr_pkg::REG_FRAMES_IN_USE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frames_q <= apr_pkg::FRAMES_RESET;
    end else if (cfg_wr) begin
      frames_q <= pwdata[apr_pkg::FRAMES_W-1:0];
    end
  end

  assign prdata = (paddr[2] == apr_pkg::REG_FRAMES_IN_USE) ?
                  apr_pkg::APB_DW'(frames_q) : '0;

  always_comb begin
    if (frames_q == '0) begin
      n_act = apr_pkg::NCNT_W'(1);
    end else if (int'(frames_q) > apr_pkg::MAX_FRAMES) begin
      n_act = apr_pkg::NCNT_W'(apr_pkg::MAX_FRAMES);
    end else begin
      n_act = apr_pkg::NCNT_W'(frames_q);
    end
  end

  // ---------------- cell chain ----------------
  assign tok_w[0] = '0;

  for (genvar g = 0; g < apr_pkg::MAX_FRAMES; g++) begin : g_cell
    apr_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .idx_i  (apr_pkg::IDX_W'(g)),
      .cmd_i  (cmd),
      .tok_i  (tok_w[g]),
      .tok_o  (tok_w[g+1])
    );
  end

  assign fin = tok_w[apr_pkg::MAX_FRAMES];

  always_comb begin
    if (fin.found) begin
      slot = fin.fidx;
    end else if (fin.hemp) begin
      slot = fin.eidx;
    end else begin
      slot = fin.bidx;
    end
  end

  // ---------------- control ----------------
  assign in_i.ready = (state_q == ST_IDLE);
  assign in_fire    = in_i.valid && in_i.ready;
  assign commit     = (state_q == ST_COMMIT) && (!out_valid_q || out_o.ready);

  always_comb begin
    cmd.clear  = in_fire && in_i.data.restart;
    cmd.commit = commit;
    cmd.hit    = fin.found;
    cmd.slot   = slot;
    cmd.page   = page_q;
    cmd.n_act  = n_act;
  end

  always_comb begin
    fault_d = fault_q;
    if (!fin.found && (fault_q != apr_pkg::FAULT_MAX)) begin
      fault_d = fault_q + apr_pkg::FAULT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      page_q      <= '0;
      fault_q     <= '0;
      out_valid_q <= 1'b0;
      out_q       <= '0;
    end else begin
      if (out_valid_q && out_o.ready && !commit) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (in_fire) begin
            page_q  <= in_i.data.page_ref;
            cnt_q   <= '0;
            state_q <= ST_SCAN;
            if (in_i.data.restart) begin
              fault_q <= '0;
            end
          end
        end
        ST_SCAN: begin
          // stay here until the token has left the last cell
          cnt_q <= cnt_q + apr_pkg::IDX_W'(1);
          if (cnt_q == apr_pkg::IDX_W'(apr_pkg::MAX_FRAMES - 1)) begin
            state_q <= ST_COMMIT;
          end
        end
        ST_COMMIT: begin
          if (commit) begin
            fault_q                 <= fault_d;
            out_valid_q             <= 1'b1;
            out_q.hit               <= fin.found;
            out_q.frame_index       <= slot[apr_pkg::FRAME_INDEX_W-1:0];
            out_q.evicted_valid     <= !fin.found && !fin.hemp;
            out_q.evicted_page      <= (!fin.found && !fin.hemp) ? fin.bpage : '0;
            out_q.fault_count       <= fault_d;
            state_q                 <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign out_o.valid = out_valid_q;
  assign out_o.data  = out_q;

`ifndef SYNTHESIS
  // the chosen frame always lies among the active frames
  a_slot_active: assert property (@(posedge clk_i) disable iff (!rst_ni)
    commit |-> ({1'b0, slot} < n_act))
    else $error("commit slot outside active frames");

  // fault count only drops on a restart
  a_fault_mono: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_fire && in_i.data.restart) |=> (fault_q >= $past(fault_q)))
    else $error("fault count decreased without restart");

  // a new result appears only right after a commit
  a_out_from_commit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(commit))
    else $error("result without commit");

  // a hit never reports an eviction
  a_hit_no_evict: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (commit && fin.found) |=> (out_q.hit && !out_q.evicted_valid))
    else $error("eviction reported on hit");
`endif

endmodule

[bench/aging_page_replacement_tb.sv]
// ----------------------------------------------------------------------------
// aging_page_replacement_tb
// Self-checking bench for the aging page replacement block.
// ----------------------------------------------------------------------------
// A directed run at the reset frame count hits fill, hit, eviction, restart
// and ties between decayed ages. It is followed by random reference streams
// drawn from working sets sized to the frame count. The frame count is
// rewritten over APB between phases, through 0 and 31 as well. A tracker
// class keeps its own copy of the frames, predicts every result, and checks
// the results in order. Both channels idle at random. One phase runs without
// gaps. In one phase the output is held off long enough to back up the input.
// ----------------------------------------------------------------------------
module aging_page_replacement_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned LIMIT_CYCLES = 400000;
  localparam int unsigned SETTLE_CYCLES = apr_pkg::MAX_FRAMES + 6;
  localparam int unsigned HOLD_OFF_CYCLES = 400;
  localparam int unsigned PHASE_REFS = 60;
  localparam int unsigned NUM_PHASES = 10;
  localparam int unsigned IDLE_PCT = 16;
  localparam logic [apr_pkg::APB_AW-1:0] FRAMES_REG_ADDR = 3'd0;
  localparam logic [apr_pkg::APB_AW-1:0] UNUSED_REG_ADDR = 3'd4;

  // tracks resident pages and ages, predicts one outcome per reference
  class replacement_tracker;
    logic [apr_pkg::PAGE_BITS-1:0] held_page [apr_pkg::MAX_FRAMES];
    bit                            occupied  [apr_pkg::MAX_FRAMES];
    bit [apr_pkg::AGE_W-1:0]       age       [apr_pkg::MAX_FRAMES];
    bit [apr_pkg::FAULT_W-1:0]     faults;
    bit [apr_pkg::FRAMES_W-1:0]    frames_cfg;
    apr_pkg::out_t                 outcome_q [$];
    int unsigned                   errors;

    function new();
      clear_frames();
      frames_cfg = apr_pkg::FRAMES_RESET;
      errors = 0;
    endfunction

    function void clear_frames();
      for (int i = 0; i < apr_pkg::MAX_FRAMES; i++) begin
        held_page[i] = '0;
        occupied[i] = 1'b0;
        age[i] = '0;
      end
      faults = '0;
    endfunction

    function int active_count();
      int n;
      n = frames_cfg;
      if (n < 1) n = 1;
      if (n > apr_pkg::MAX_FRAMES) n = apr_pkg::MAX_FRAMES;
      return n;
    endfunction

    function void note_reference(apr_pkg::in_t req);
      int n;
      int slot;
      int best;
      bit found;
      bit empty_seen;
      apr_pkg::out_t res;
      slot = 0;
      found = 1'b0;
      empty_seen = 1'b0;
      best = 256;
      res = '0;
      if (req.restart) clear_frames();
      n = active_count();
      for (int i = 0; i < n; i++) age[i] = age[i] >> 1;
      for (int i = 0; i < n; i++) begin
        if (!found && occupied[i] && held_page[i] == req.page_ref) begin
          slot = i;
          found = 1'b1;
        end
      end
      if (found) begin
        age[slot] = age[slot] | apr_pkg::AGE_TOP;
      end else begin
        if (faults != apr_pkg::FAULT_MAX) faults = faults + 1'b1;
        for (int i = 0; i < n; i++) begin
          if (!empty_seen) begin
            if (!occupied[i]) begin
              slot = i;
              empty_seen = 1'b1;
            end else if (int'(age[i]) < best) begin
              best = age[i];
              slot = i;
            end
          end
        end
        if (!empty_seen) begin
          res.evicted_valid = 1'b1;
          res.evicted_page = held_page[slot];
        end
        held_page[slot] = req.page_ref;
        occupied[slot] = 1'b1;
        age[slot] = apr_pkg::AGE_TOP;
      end
      res.hit = found;
      res.frame_index = slot[apr_pkg::FRAME_INDEX_W-1:0];
      res.fault_count = faults;
      outcome_q.insert(outcome_q.size(), res);
    endfunction

    function void compare_field(string name, logic [apr_pkg::FAULT_W-1:0] want_v,
                                logic [apr_pkg::FAULT_W-1:0] got_v);
      if (got_v !== want_v) begin
        $error("%s: expected %0h, got %0h", name, want_v, got_v);
        errors++;
      end
    endfunction

    function void check_outcome(apr_pkg::out_t got);
      apr_pkg::out_t want;
      if (outcome_q.size() == 0) begin
        $error("result with no reference outstanding: %p", got);
        errors++;
        return;
      end
      want = outcome_q.pop_front();
      compare_field("hit", want.hit, got.hit);
      compare_field("frame_index", want.frame_index, got.frame_index);
      compare_field("evicted_valid", want.evicted_valid, got.evicted_valid);
      compare_field("evicted_page", want.evicted_page, got.evicted_page);
      compare_field("fault_count", want.fault_count, got.fault_count);
    endfunction
  endclass

  logic                       clk_i;
  logic                       rst_ni;
  logic                       psel;
  logic                       penable;
  logic                       pwrite;
  logic [apr_pkg::APB_AW-1:0] paddr;
  logic [apr_pkg::APB_DW-1:0] pwdata;
  logic [apr_pkg::APB_DW-1:0] prdata;
  logic                       pready;

  apr_in_if  in_ch ();
  apr_out_if out_ch ();

  replacement_tracker tracker = new();

  bit          quiet;
  bit          hold_req;
  bit          hold_done;
  int unsigned hold_left;
  int unsigned cycles;

  bit [apr_pkg::APB_DW-1:0] frame_settings [NUM_PHASES] =
    '{16, 1, 0, 31, 7, 2, 16, 9, 3, 16};

  aging_page_replacement dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_i    (in_ch),
    .out_o   (out_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycles++;
    if (cycles >= LIMIT_CYCLES) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // result side: check transfers, then pick ready for the next cycle
  always @(posedge clk_i) begin
    if (rst_ni && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
      tracker.check_outcome(out_ch.data);
    end
    if (hold_req && !hold_done) begin
      hold_left = HOLD_OFF_CYCLES;
      hold_done = 1'b1;
    end
    if (hold_left != 0) begin
      hold_left--;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= quiet || ($urandom_range(99) >= IDLE_PCT);
    end
  end

  task automatic send_reference(logic [apr_pkg::PAGE_BITS-1:0] page, bit restart);
    apr_pkg::in_t item;
    item.page_ref = page;
    item.restart = restart;
    if (!quiet && $urandom_range(99) < IDLE_PCT) begin
      in_ch.valid <= 1'b0;
      in_ch.data <= apr_pkg::in_t'($urandom);
      do @(posedge clk_i); while ($urandom_range(99) < IDLE_PCT);
    end
    in_ch.valid <= 1'b1;
    in_ch.data <= item;
    do @(posedge clk_i); while (in_ch.ready !== 1'b1);
    tracker.note_reference(item);
  endtask

  // wait for the block to drain before touching the register
  task automatic settle();
    in_ch.valid <= 1'b0;
    while (tracker.outcome_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic apb_write(logic [apr_pkg::APB_AW-1:0] addr,
                           logic [apr_pkg::APB_DW-1:0] value);
    @(posedge clk_i);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (pready !== 1'b1);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (addr == FRAMES_REG_ADDR) tracker.frames_cfg = value[apr_pkg::FRAMES_W-1:0];
  endtask

  // working set of the frame count plus up to three pages, drifting over time
  task automatic run_stream(int unsigned count);
    logic [apr_pkg::PAGE_BITS-1:0] pool [$];
    int unsigned                   r;
    int unsigned                   set_size;
    set_size = tracker.active_count() + $urandom_range(0, 3);
    for (int i = 0; i < set_size; i++) begin
      pool.insert(pool.size(), apr_pkg::PAGE_BITS'($urandom));
    end
    for (int k = 0; k < count; k++) begin
      if ($urandom_range(99) < 5) begin
        pool[$urandom_range(set_size - 1)] = apr_pkg::PAGE_BITS'($urandom);
      end
      r = $urandom_range(99);
      if (r < 3)
        send_reference(pool[$urandom_range(set_size - 1)], 1'b1);
      else if (r < 13)
        send_reference(apr_pkg::PAGE_BITS'($urandom), 1'b0);
      else
        send_reference(pool[$urandom_range(set_size - 1)], 1'b0);
    end
  endtask

  initial begin
    logic [apr_pkg::APB_DW-1:0] wdata;
    rst_ni = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    in_ch.valid = 1'b0;
    in_ch.data = '0;
    out_ch.ready = 1'b0;
    quiet = 1'b0;
    hold_req = 1'b0;
    hold_done = 1'b0;
    hold_left = 0;
    cycles = 0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset frame count of four
    send_reference(16'h0000, 1'b0);
    send_reference(16'hFFFF, 1'b0);
    send_reference(16'h0000, 1'b0);
    send_reference(16'h1234, 1'b0);
    send_reference(16'h8001, 1'b0);
    send_reference(16'h5555, 1'b0);
    send_reference(16'hAAAA, 1'b0);
    send_reference(16'hFFFF, 1'b0);
    send_reference(16'hFFFF, 1'b1);
    send_reference(16'hFFFF, 1'b0);
    send_reference(16'hFFFF, 1'b1);
    send_reference(16'h0001, 1'b0);
    send_reference(16'h0002, 1'b0);
    send_reference(16'h0003, 1'b0);
    // let every other age decay to zero, then force a tie on the miss
    repeat (9) send_reference(16'hFFFF, 1'b0);
    send_reference(16'h4444, 1'b0);
    settle();

    for (int p = 0; p < NUM_PHASES; p++) begin
      wdata = frame_settings[p];
      if (p % 2 == 1) begin
        wdata = ($urandom & ~apr_pkg::APB_DW'(5'h1F)) | frame_settings[p];
      end
      apb_write(FRAMES_REG_ADDR, wdata);
      if (p == 4) apb_write(UNUSED_REG_ADDR, apr_pkg::APB_DW'(1));
      quiet = (p == 5);
      if (p == 1) hold_req = 1'b1;
      run_stream(PHASE_REFS);
      settle();
    end
    quiet = 1'b0;

    if (tracker.outcome_q.size() != 0) begin
      $error("%0d results never arrived", tracker.outcome_q.size());
    end
    if (tracker.errors == 0 && tracker.outcome_q.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

[files.f]
sv/apr_pkg.sv
sv/apr_if.sv
sv/apr_cell.sv
sv/aging_page_replacement.sv
bench/aging_page_replacement_tb.sv
